// File: hdl/lkvc_pkg.sv
// Package for the LRU key-value cache: item types, command codes, memory strobes, FSM states.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

	localparam int unsigned ENTRIES_DEF = 16;
	localparam int unsigned KEY_W       = 32;
	localparam int unsigned VAL_W       = 31;
	localparam int unsigned CAP_W       = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic signed [KEY_W-1:0] key;
		logic [VAL_W-1:0]        value;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
	} rsp_t;

	// memory strobes from the sequencer to the store
	typedef struct packed {
		logic rd_en;
		logic kd_we;
		logic rk_we;
	} mem_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_UPDATE,
		ST_PROMOTE,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// File: hdl/lkvc_store.sv
// Entry storage: key/data memory and recency rank memory, both with registered reads.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_store import lkvc_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                    clk,
	input  mem_ctl_t                ctl,
	input  logic [IW-1:0]           rd_addr,
	input  logic [IW-1:0]           wr_addr,
	input  logic signed [KEY_W-1:0] wr_key,
	input  logic [VAL_W-1:0]        wr_data,
	input  logic [IW-1:0]           wr_rank,
	output logic signed [KEY_W-1:0] rd_key,
	output logic [VAL_W-1:0]        rd_data,
	output logic [IW-1:0]           rd_rank
);

	logic [KEY_W+VAL_W-1:0] kd_mem [ENTRIES];
	logic [IW-1:0]          rank_mem [ENTRIES];
	logic [KEY_W+VAL_W-1:0] kd_rd_q;

	always_ff @(posedge clk) begin
		if (ctl.kd_we) begin
			kd_mem[wr_addr] <= {wr_key, wr_data};
		end
		if (ctl.rd_en) begin
			kd_rd_q <= kd_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rk_we) begin
			rank_mem[wr_addr] <= wr_rank;
		end
		if (ctl.rd_en) begin
			rd_rank <= rank_mem[rd_addr];
		end
	end

	assign rd_key  = kd_rd_q[KEY_W+VAL_W-1:VAL_W];
	assign rd_data = kd_rd_q[VAL_W-1:0];

endmodule

`default_nettype wire

// File: hdl/lkvc_ctrl.sv
// Sequencer: search sweep, hit/evict/insert decision, entry write, rank promote sweep.
// Depends on lkvc_pkg; drives lkvc_store.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ctrl import lkvc_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	parameter int unsigned CW      = $clog2(ENTRIES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  req_t                    req,
	input  logic [CW-1:0]           cap_eff,
	output logic                    busy,
	output logic                    res_valid,
	output rsp_t                    res,
	input  logic                    res_take,
	output mem_ctl_t                ctl,
	output logic [IW-1:0]           rd_addr,
	output logic [IW-1:0]           wr_addr,
	output logic signed [KEY_W-1:0] wr_key,
	output logic [VAL_W-1:0]        wr_data,
	output logic [IW-1:0]           wr_rank,
	input  logic signed [KEY_W-1:0] rd_key,
	input  logic [VAL_W-1:0]        rd_data,
	input  logic [IW-1:0]           rd_rank
);

	state_t state_q, state_d;

	// control
	logic [CW-1:0] cnt_q;      // valid entries occupy slots 0..cnt_q-1
	logic [CW-1:0] idx_q;      // sweep read pointer
	logic          pend_s1;    // read data returns this cycle
	logic          found_q;

	// item and sweep payload
	logic [IW-1:0]           addr_s1;
	cmd_t                    cmd_q;
	logic signed [KEY_W-1:0] key_q;
	logic [VAL_W-1:0]        val_q;
	logic [IW-1:0]           slot_q;
	logic [IW-1:0]           bound_q;  // ranks below this move down one place
	logic [IW-1:0]           lru_q;
	logic                    hit_q;
	logic [VAL_W-1:0]        rdata_q;

	logic issue, match_now, grow, evict;

	assign match_now = (state_q == ST_SEARCH) && pend_s1 && (rd_key == key_q);
	assign grow      = !found_q && (cmd_q == CMD_PUT) && (cnt_q < cap_eff);
	assign evict     = !found_q && (cmd_q == CMD_PUT) && !(cnt_q < cap_eff);
	assign issue     = ((state_q == ST_SEARCH) && (idx_q != cnt_q) && !found_q && !match_now)
		|| ((state_q == ST_PROMOTE) && (idx_q != cnt_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if ((found_q || (idx_q == cnt_q)) && !pend_s1) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!found_q && (cmd_q == CMD_GET)) state_d = ST_DONE;
				else state_d = ST_UPDATE;
			end
			ST_UPDATE:  state_d = ST_PROMOTE;
			ST_PROMOTE: begin
				if ((idx_q == cnt_q) && !pend_s1) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_take) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.rd_en = issue;
		ctl.kd_we = (state_q == ST_UPDATE) && (cmd_q == CMD_PUT);
		ctl.rk_we = (state_q == ST_UPDATE)
			|| ((state_q == ST_PROMOTE) && pend_s1 && (addr_s1 != slot_q)
				&& (rd_rank < bound_q));
		rd_addr   = idx_q[IW-1:0];
		wr_addr   = (state_q == ST_UPDATE) ? slot_q : addr_s1;
		wr_rank   = (state_q == ST_UPDATE) ? '0 : rd_rank + IW'(1);
		wr_key    = key_q;
		wr_data   = val_q;
		busy      = (state_q != ST_IDLE);
		res_valid = (state_q == ST_DONE);
		res.hit        = hit_q;
		res.read_value = rdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			pend_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (issue) idx_q <= idx_q + CW'(1);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						found_q <= 1'b0;
					end
				end
				ST_SEARCH: begin
					if (match_now) found_q <= 1'b1;
				end
				ST_DECIDE: begin
					idx_q <= '0;
					if (grow) cnt_q <= cnt_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) addr_s1 <= rd_addr;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q <= req.cmd;
					key_q <= req.key;
					val_q <= req.value;
				end
			end
			ST_SEARCH: begin
				if (match_now) begin
					slot_q  <= addr_s1;
					bound_q <= rd_rank;
					rdata_q <= rd_data;
				end
				if (pend_s1 && (CW'(rd_rank) == cnt_q - CW'(1))) lru_q <= addr_s1;
			end
			ST_DECIDE: begin
				hit_q <= found_q;
				if (!found_q) rdata_q <= '0;
				if (evict) begin
					slot_q  <= lru_q;
					bound_q <= IW'(cnt_q - CW'(1));
				end
				if (grow) begin
					slot_q  <= cnt_q[IW-1:0];
					bound_q <= cnt_q[IW-1:0];
				end
			end
			default: ;
		endcase
	end

	a_start_search: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == ST_SEARCH)
		else $error("accepted item did not start a search");

	a_promote_skips_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROMOTE) && ctl.rk_we |-> wr_addr != slot_q)
		else $error("promote sweep overwrote the promoted slot rank");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> cnt_q == $past(cnt_q) + CW'(1))
		else $error("entry count changed by other than one");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) || (state_q == ST_PROMOTE) |-> idx_q <= cnt_q)
		else $error("sweep pointer passed the entry count");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_take |=> !busy)
		else $error("sequencer held after its result was taken");

endmodule

`default_nettype wire

// File: hdl/lru_key_value_cache_top.sv
// Top level of the LRU key-value cache: capacity register, result register,
// sequencer and entry store. Depends on lkvc_pkg, lkvc_ctrl, lkvc_store.
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
// Each item on the req channel is a get or a put of a 32-bit key; each gives
// exactly one item on the rsp channel: hit and the value held before the item
// (0 on a miss). A get miss changes nothing; a put miss inserts the key as most
// recent, evicting the least recent entry once the held count reaches the
// capacity register (0 acts as 1, values above ENTRIES act as ENTRIES; lowering
// it never evicts at once, later misses replace in place). Keys, values and
// recency ranks live in two single-port-read memories indexed by slot; valid
// entries always fill slots 0..N-1, so a fill count replaces valid bits and no
// clearing pass runs after reset. From one accepted item to the next, a get
// miss runs a search sweep over all held entries, decide, done (which waits
// for the result register to free) and idle; a hit stops its search at the
// matching slot, then runs decide, a write state, a rank promote sweep, done
// and idle; a put miss runs the same steps after a full search, and when it
// inserts, its promote sweep also covers the new entry. Each sweep issues one
// memory read per cycle. One item is in work at a time; req_stall is high
// while it is, and the next item is taken even while the previous result
// still waits in the output register. The capacity port always accepts;
// write it only while the block is idle.

module lru_key_value_cache_top import lkvc_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// request items
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	// result items
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	// capacity register write
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	logic [CAP_W-1:0] capacity_q;
	logic [CW-1:0]    cap_eff;

	logic             busy, res_valid, out_free, start;
	rsp_t             res;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	mem_ctl_t                ctl;
	logic [IW-1:0]           rd_addr, wr_addr, wr_rank, rd_rank;
	logic signed [KEY_W-1:0] wr_key, rd_key;
	logic [VAL_W-1:0]        wr_data, rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// zero reads as one, anything above the entry count saturates
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CW'(1);
		end else if (32'(capacity_q) > 32'(ENTRIES)) begin
			cap_eff = CW'(ENTRIES);
		end else begin
			cap_eff = CW'(capacity_q);
		end
	end

	assign req_stall = busy;
	assign start     = req_valid && !busy;

	// result register: refills as soon as the old item leaves
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) rsp_q <= res;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	lkvc_ctrl #(
		.ENTRIES (ENTRIES),
		.IW      (IW),
		.CW      (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.cap_eff   (cap_eff),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (out_free),
		.ctl       (ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.wr_key    (wr_key),
		.wr_data   (wr_data),
		.wr_rank   (wr_rank),
		.rd_key    (rd_key),
		.rd_data   (rd_data),
		.rd_rank   (rd_rank)
	);

	lkvc_store #(
		.ENTRIES (ENTRIES),
		.IW      (IW)
	) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_data (wr_data),
		.wr_rank (wr_rank),
		.rd_key  (rd_key),
		.rd_data (rd_data),
		.rd_rank (rd_rank)
	);

endmodule

`default_nettype wire
